// ===== rtl/serpentine_error_diffusion_dither_unit_assert.svh =====
// Assertion macros shared by the dither unit modules.
`ifndef SERPENTINE_ERROR_DIFFUSION_DITHER_UNIT_ASSERT_SVH
`define SERPENTINE_ERROR_DIFFUSION_DITHER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SEDD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SEDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sedd_pkg.sv =====
package sedd_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int QUEUE_DEPTH   = 4;
    localparam int DIV_STEPS     = 16;

    typedef logic [2:0] cfg_index_t;
    localparam cfg_index_t CFG_SOURCE_DEPTH  = 3'd0;
    localparam cfg_index_t CFG_DEST_DEPTH    = 3'd1;
    localparam cfg_index_t CFG_QUANT_DEPTH   = 3'd2;
    localparam cfg_index_t CFG_LINE_WIDTH    = 3'd3;
    localparam cfg_index_t CFG_RANGE_CONVERT = 3'd4;
    localparam cfg_index_t CFG_SRC_OFFSET    = 3'd5;
    localparam cfg_index_t CFG_RANGE_GAIN    = 3'd6;
    localparam cfg_index_t CFG_DST_OFFSET    = 3'd7;

    typedef struct packed {
        logic [4:0] sd;
        logic [4:0] dd;
        logic [3:0] qd;
        logic       low;
    } depth_t;

    typedef struct packed {
        logic               enable;
        logic [15:0]        src_offset;
        logic [17:0]        gain;
        logic signed [16:0] dst_offset;
    } range_cfg_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_CALC,
        B_UPD3,
        B_UPD5,
        B_CARRY,
        B_DIV,
        B_EMIT
    } back_state_t;

    // Clamp raw depth registers to their legal ranges.
    function automatic depth_t derive_depths(logic [4:0] sd_raw, logic [4:0] dd_raw,
                                             logic [3:0] qd_raw);
        depth_t     d;
        logic [4:0] qlim;
        d.sd = (sd_raw < 5'd8) ? 5'd8 : ((sd_raw > 5'd16) ? 5'd16 : sd_raw);
        d.dd = (dd_raw < 5'd8) ? 5'd8 : ((dd_raw > d.sd) ? d.sd : dd_raw);
        qlim = (d.dd < d.sd - 5'd1) ? d.dd : d.sd - 5'd1;
        if (qd_raw == 4'd0)
        begin
            d.qd = 4'd1;
        end
        else if ({1'b0, qd_raw} > qlim)
        begin
            d.qd = qlim[3:0];
        end
        else
        begin
            d.qd = qd_raw;
        end
        d.low = (d.qd < 4'd8);
        return d;
    endfunction

endpackage

// ===== rtl/sedd_front.sv =====
module sedd_front #(
    parameter int MAX_WIDTH = 4096,
    parameter int CW        = 12,
    parameter int QW        = 30
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,
    input  logic                s_tuser,
    input  sedd_pkg::depth_t    depths,
    input  sedd_pkg::range_cfg_t rcfg,
    input  logic [12:0]         line_width,
    input  logic                clearing,
    output logic                push,
    input  logic                push_ready,
    output logic [QW-1:0]       push_data
);
    import sedd_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [WW-1:0] w_eff, cnt_reg, cnt_next, cnt_base, cnt_inc;
    logic          odd_reg, odd_next, odd_base;
    logic [15:0]   smax;
    logic [WW-1:0] x_full;

    logic          s1_valid_reg;
    logic [15:0]   s1_value_reg;
    logic [CW-1:0] s1_x_reg;
    logic          s1_dir_reg, s1_restart_reg;

    logic                 s2_valid_reg;
    logic signed [35:0]   s2_prod_reg;
    logic [15:0]          s2_value_reg;
    logic [CW-1:0]        s2_x_reg;
    logic                 s2_dir_reg, s2_restart_reg;

    logic               accept, s2_free, adv1;
    logic signed [36:0] t_w;
    logic [15:0]        conv_w, value_w;

    always_comb
    begin
        if (line_width == 13'd0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(line_width) > MAX_WIDTH)
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(line_width);
        end
    end

    assign smax     = 16'((17'(1) << depths.sd) - 17'd1);
    assign s2_free  = !s2_valid_reg || push;
    assign adv1     = s1_valid_reg && s2_free;
    assign s_tready = !clearing && (!s1_valid_reg || s2_free);
    assign accept   = s_tvalid && s_tready;

    // Column walk: restart first, wrap a stale count, then step.
    always_comb
    begin
        cnt_base = s_tuser ? '0 : cnt_reg;
        odd_base = s_tuser ? 1'b0 : odd_reg;
        if (cnt_base >= w_eff)
        begin
            cnt_base = '0;
        end
        x_full   = odd_base ? (w_eff - WW'(1) - cnt_base) : cnt_base;
        cnt_inc  = cnt_base + WW'(1);
        cnt_next = cnt_reg;
        odd_next = odd_reg;
        if (accept)
        begin
            cnt_next = (cnt_inc >= w_eff) ? '0 : cnt_inc;
            odd_next = (cnt_inc >= w_eff) ? !odd_base : odd_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            odd_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            odd_reg <= odd_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (adv1)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (adv1)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (push)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_value_reg   <= s_tdata & smax;
            s1_x_reg       <= CW'(x_full);
            s1_dir_reg     <= odd_base;
            s1_restart_reg <= s_tuser;
        end
        if (adv1)
        begin
            s2_prod_reg    <= 36'($signed({1'b0, s1_value_reg}) - $signed({1'b0, rcfg.src_offset}))
                              * $signed({1'b0, rcfg.gain});
            s2_value_reg   <= s1_value_reg;
            s2_x_reg       <= s1_x_reg;
            s2_dir_reg     <= s1_dir_reg;
            s2_restart_reg <= s1_restart_reg;
        end
    end

    // Offset, round and clamp the converted sample.
    always_comb
    begin
        t_w = 37'(s2_prod_reg) + (37'(rcfg.dst_offset) <<< 16) + 37'sd32768;
        if (t_w[36])
        begin
            conv_w = 16'd0;
        end
        else if (t_w[36:16] > 21'(smax))
        begin
            conv_w = smax;
        end
        else
        begin
            conv_w = t_w[31:16];
        end
        value_w = rcfg.enable ? conv_w : s2_value_reg;
    end

    assign push      = s2_valid_reg && push_ready;
    assign push_data = {s2_restart_reg, s2_dir_reg, s2_x_reg, value_w};

endmodule

// ===== rtl/sedd_queue.sv =====
`include "serpentine_error_diffusion_dither_unit_assert.svh"
module sedd_queue #(
    parameter int W = 30
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic         pop_valid,
    output logic [W-1:0] pop_data
);
    import sedd_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]  slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] count_reg;

    assign push_ready = (count_reg != NW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `SEDD_ASSERT_NOW(a_queue_bound, 1'b1, count_reg <= NW'(QUEUE_DEPTH), "queue over depth")
    `SEDD_ASSERT_NOW(a_queue_pop, pop, count_reg != '0, "pop from empty queue")

endmodule

// ===== rtl/sedd_back.sv =====
`include "serpentine_error_diffusion_dither_unit_assert.svh"
module sedd_back #(
    parameter int MAX_WIDTH = 4096,
    parameter int CW        = 12,
    parameter int QW        = 30
) (
    input  logic             clk,
    input  logic             rst_n,
    input  sedd_pkg::depth_t depths,
    input  logic             pop_valid,
    input  logic [QW-1:0]    pop_data,
    output logic             pop,
    output logic             clearing,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata
);
    import sedd_pkg::*;

    localparam int DEPTH = MAX_WIDTH + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int DCW   = $clog2(DIV_STEPS + 1);

    back_state_t state_reg, state_next;

    logic [15:0]        value_reg;
    logic [CW-1:0]      x_reg;
    logic               dir_reg, pend_reg, pend_next;
    logic signed [19:0] carry_reg, carry_next;
    logic signed [21:0] err_reg, q_reg;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [8:0]         rem_reg, rem_next;
    logic [15:0]        num_reg, num_next, quo_reg, quo_next;
    logic [DCW-1:0]     dcnt_reg, dcnt_next;
    logic               out_valid_reg;
    logic [15:0]        out_value_reg, res_reg, res_next;
    logic [CW-1:0]      out_col_reg;

    logic [19:0]   mem [DEPTH];
    logic [19:0]   rdata_reg;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [19:0]   wdata;

    logic [AW-1:0]      a_here, a_behind, a_ahead;
    logic [4:0]         shift_w, osh_w;
    logic signed [21:0] rounder_w, sum_w, qt_w, err_w;
    logic signed [25:0] e3_w, e5_w, e7_w;
    logic [15:0]        maxo_w, res_norm_w;
    logic [7:0]         qmax_w, qc_w;
    logic [39:0]        shifted_w;
    logic [24:0]        num_w;
    logic [9:0]         r2_w;
    logic               ge_w, load_item, out_load;

    assign a_here   = AW'(x_reg) + AW'(1);
    assign a_behind = dir_reg ? AW'(x_reg) + AW'(2) : AW'(x_reg);
    assign a_ahead  = dir_reg ? AW'(x_reg) : AW'(x_reg) + AW'(2);

    assign shift_w   = depths.sd - 5'(depths.qd);
    assign osh_w     = depths.dd - 5'(depths.qd);
    assign rounder_w = $signed(22'(1) << (shift_w - 5'd1));
    assign maxo_w    = 16'((17'(1) << depths.dd) - 17'd1);
    assign qmax_w    = 8'((9'(1) << depths.qd) - 9'd1);

    // Add carried error and quantize by arithmetic shift.
    always_comb
    begin
        sum_w = $signed({6'd0, value_reg}) + 22'(carry_reg)
                - (depths.low ? rounder_w : 22'sd0);
        qt_w  = (sum_w + rounder_w) >>> shift_w;
        err_w = sum_w - (qt_w <<< shift_w);
    end

    // Split the residual into the 4/16, 5/16 and remaining parts.
    always_comb
    begin
        e3_w = ((26'(err_reg) <<< 2) + 26'sd8) >>> 4;
        e5_w = ((26'(err_reg) <<< 2) + 26'(err_reg) + 26'sd8) >>> 4;
        e7_w = 26'(err_reg) - e3_w - e5_w;
    end

    always_comb
    begin
        shifted_w = 40'(q_reg[20:0]) << osh_w;
        if (q_reg[21])
        begin
            res_norm_w = 16'd0;
        end
        else if (shifted_w > 40'(maxo_w))
        begin
            res_norm_w = maxo_w;
        end
        else
        begin
            res_norm_w = shifted_w[15:0];
        end
        qc_w  = (q_reg > 22'(qmax_w)) ? qmax_w : q_reg[7:0];
        num_w = ((25'(qc_w) * 25'(maxo_w)) << 1) + 25'(qmax_w);
        r2_w  = {rem_reg, num_reg[15]};
        ge_w  = (r2_w >= {1'b0, qmax_w, 1'b0});
    end

    assign out_load = !out_valid_reg || m_tready;
    assign clearing = (state_reg == B_CLEAR);

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        carry_next = carry_reg;
        clr_next   = clr_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        dcnt_next  = dcnt_reg;
        res_next   = res_reg;
        pop        = 1'b0;
        load_item  = 1'b0;
        we         = 1'b0;
        waddr      = a_here;
        wdata      = 20'd0;
        raddr      = a_here;
        case (state_reg)
            B_CLEAR:
            begin
                we         = 1'b1;
                waddr      = clr_reg;
                carry_next = '0;
                clr_next   = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    clr_next   = '0;
                    pend_next  = 1'b0;
                    state_next = pend_reg ? B_CALC : B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    pop       = 1'b1;
                    load_item = 1'b1;
                    if (pop_data[QW-1])
                    begin
                        pend_next  = 1'b1;
                        state_next = B_CLEAR;
                    end
                    else
                    begin
                        state_next = B_CALC;
                    end
                end
            end
            B_CALC:
            begin
                raddr      = a_behind;
                state_next = B_UPD3;
            end
            B_UPD3:
            begin
                we         = 1'b1;
                waddr      = a_behind;
                wdata      = rdata_reg + e3_w[19:0];
                raddr      = a_here;
                state_next = B_UPD5;
            end
            B_UPD5:
            begin
                we         = 1'b1;
                waddr      = a_here;
                wdata      = rdata_reg + e5_w[19:0];
                raddr      = a_ahead;
                state_next = B_CARRY;
            end
            B_CARRY:
            begin
                we         = 1'b1;
                waddr      = a_ahead;
                carry_next = $signed(rdata_reg) + e7_w[19:0];
                if (!depths.low)
                begin
                    res_next   = res_norm_w;
                    state_next = B_EMIT;
                end
                else if (q_reg <= 22'sd0)
                begin
                    res_next   = 16'd0;
                    state_next = B_EMIT;
                end
                else
                begin
                    rem_next   = num_w[24:16];
                    num_next   = num_w[15:0];
                    quo_next   = '0;
                    dcnt_next  = DCW'(DIV_STEPS);
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                rem_next  = ge_w ? 9'(r2_w - {1'b0, qmax_w, 1'b0}) : r2_w[8:0];
                quo_next  = {quo_reg[14:0], ge_w};
                num_next  = {num_reg[14:0], 1'b0};
                dcnt_next = dcnt_reg - DCW'(1);
                if (dcnt_reg == DCW'(1))
                begin
                    res_next   = {quo_reg[14:0], ge_w};
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (out_load)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            pend_reg      <= 1'b0;
            carry_reg     <= '0;
            clr_reg       <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            carry_reg <= carry_next;
            clr_reg   <= clr_next;
            dcnt_reg  <= dcnt_next;
            if (state_reg == B_EMIT && out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        res_reg <= res_next;
        if (load_item)
        begin
            value_reg <= pop_data[15:0];
            x_reg     <= pop_data[CW+15:16];
            dir_reg   <= pop_data[CW+16];
        end
        if (state_reg == B_CALC)
        begin
            q_reg   <= qt_w;
            err_reg <= err_w;
        end
        if (state_reg == B_EMIT && out_load)
        begin
            out_value_reg <= res_reg;
            out_col_reg   <= x_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, 12'(out_col_reg), out_value_reg};

    `SEDD_ASSERT_NOW(a_div_count, state_reg == B_DIV, dcnt_reg != '0, "divider ran out of steps")
    `SEDD_ASSERT_NEXT(a_emit_loads, state_reg == B_EMIT && out_load, out_valid_reg,
                      "result not held after emit")
    `SEDD_ASSERT_NOW(a_no_pop_busy, pop, state_reg == B_IDLE, "pop outside idle")

endmodule

// ===== rtl/serpentine_error_diffusion_dither_unit.sv =====
// Sequencing: the back sequencer takes one pixel at a time through three serial line-store
//   updates on one memory port, plus, in low mode when the quantized level is above zero, a
//   16-step bit-serial divider for the rescale.
// Reset: rst_n clears control state at once; the line store is then zeroed by a pass over
//   all MAX_WIDTH+2 slots (4098 by default), repeated for each restart beat.
module serpentine_error_diffusion_dither_unit #(
    parameter int MAX_WIDTH = sedd_pkg::MAX_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] pixel
    input  logic        s_tuser,   // [0] restart
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] out_value, [27:16] column, [31:28] zero
    // configuration writes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [17:0] cfg_data
);
    import sedd_pkg::*;

    // Column index width and the packed beat carried through the queue:
    // {restart, row direction, column, sample}.
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int QW = 16 + CW + 2;

    logic [4:0]         source_depth_reg, dest_depth_reg;
    logic [3:0]         quant_depth_reg;
    logic [12:0]        line_width_reg;
    logic               range_convert_reg;
    logic [15:0]        src_offset_reg;
    logic [17:0]        range_gain_reg;
    logic signed [16:0] dst_offset_reg;

    depth_t     depths;
    range_cfg_t rcfg;

    logic          push, push_ready, pop, pop_valid, clearing;
    logic [QW-1:0] push_data, pop_data;

    // Register file: the user must write it only while the pipe is empty (the block does not
    // enforce this), so the clamped view below is settled by the time the next beat arrives.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_depth_reg  <= 5'd8;
            dest_depth_reg    <= 5'd8;
            quant_depth_reg   <= 4'd4;
            line_width_reg    <= 13'd4096;
            range_convert_reg <= 1'b0;
            src_offset_reg    <= 16'd0;
            range_gain_reg    <= 18'd65536;
            dst_offset_reg    <= 17'sd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SOURCE_DEPTH:  source_depth_reg  <= cfg_data[4:0];
                CFG_DEST_DEPTH:    dest_depth_reg    <= cfg_data[4:0];
                CFG_QUANT_DEPTH:   quant_depth_reg   <= cfg_data[3:0];
                CFG_LINE_WIDTH:    line_width_reg    <= cfg_data[12:0];
                CFG_RANGE_CONVERT: range_convert_reg <= cfg_data[0];
                CFG_SRC_OFFSET:    src_offset_reg    <= cfg_data[15:0];
                CFG_RANGE_GAIN:    range_gain_reg    <= cfg_data[17:0];
                CFG_DST_OFFSET:    dst_offset_reg    <= $signed(cfg_data[16:0]);
                default:           range_convert_reg <= range_convert_reg;
            endcase
        end
    end

    // Clamp depths once here; both halves see the same legal values.
    assign depths          = derive_depths(source_depth_reg, dest_depth_reg, quant_depth_reg);
    assign rcfg.enable     = range_convert_reg;
    assign rcfg.src_offset = src_offset_reg;
    assign rcfg.gain       = range_gain_reg;
    assign rcfg.dst_offset = dst_offset_reg;

    // Front: accept, track column and row parity, range-convert.
    sedd_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW),
        .QW        (QW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .depths     (depths),
        .rcfg       (rcfg),
        .line_width (line_width_reg),
        .clearing   (clearing),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Short queue decouples the front from the serial back end.
    sedd_queue #(
        .W (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    // Back: error add, quantize, line-store diffusion, rescale, output register.
    sedd_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW),
        .QW        (QW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .depths    (depths),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop       (pop),
        .clearing  (clearing),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== dv/serpentine_error_diffusion_dither_unit_tb.sv =====
module serpentine_error_diffusion_dither_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sedd_pkg::*;

    localparam int LINE_SLOTS  = MAX_WIDTH_DEF + 2;
    localparam int DRAIN_WAIT  = 40;        // above the low-mode latency
    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 200;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [15:0] value;
        logic [11:0] column;
    } dithered_t;

    typedef struct {
        logic [15:0] pixel;
        logic        restart;
        int          want_value;   // -1: take the value from the predictor
        int          want_column;  // -1: take the column from the predictor
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [17:0] cfg_data = '0;

    serpentine_error_diffusion_dither_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #4 clk = ~clk;

    // Shadow copy of the register file and the diffusion state.
    logic [4:0]         sh_source_depth;
    logic [4:0]         sh_dest_depth;
    logic [3:0]         sh_quant_depth;
    logic [12:0]        sh_line_width;
    logic               sh_range_convert;
    logic [15:0]        sh_src_offset;
    logic [17:0]        sh_range_gain;
    logic signed [16:0] sh_dst_offset;

    int          err_row [LINE_SLOTS];
    int          err_carry;
    int unsigned col_done;
    bit          odd_row;

    dithered_t   pending_pixels[$];
    idle_mode_t  idle_mode = IDLE_NONE;
    bit          failed = 1'b0;
    int unsigned cycles = 0;

    function automatic int floor_div(int v, int d);
        if (v >= 0)
        begin
            return v / d;
        end
        return -((-v + d - 1) / d);
    endfunction

    function automatic void clear_diffusion();
        foreach (err_row[i])
        begin
            err_row[i] = 0;
        end
        err_carry = 0;
        col_done = 0;
        odd_row = 1'b0;
    endfunction

    function automatic void shadow_write(cfg_index_t idx, logic [17:0] data);
        case (idx)
            CFG_SOURCE_DEPTH:  sh_source_depth  = data[4:0];
            CFG_DEST_DEPTH:    sh_dest_depth    = data[4:0];
            CFG_QUANT_DEPTH:   sh_quant_depth   = data[3:0];
            CFG_LINE_WIDTH:    sh_line_width    = data[12:0];
            CFG_RANGE_CONVERT: sh_range_convert = data[0];
            CFG_SRC_OFFSET:    sh_src_offset    = data[15:0];
            CFG_RANGE_GAIN:    sh_range_gain    = data[17:0];
            CFG_DST_OFFSET:    sh_dst_offset    = data[16:0];
            default: ;
        endcase
    endfunction

    // Dither one pixel and advance the diffusion state.
    function automatic dithered_t dither_pixel(logic [15:0] pixel, logic restart);
        int          sd, dd, qlim, qd, w;
        int          divisor, rounder, maxo, smax, qmax;
        bit          low;
        int          value, err, sum, q, qc, res, e3, e5, e7, dir, x, pos;
        longint      t;
        dithered_t   r;
        sd = (sh_source_depth < 8) ? 8 : ((sh_source_depth > 16) ? 16 : sh_source_depth);
        dd = (sh_dest_depth < 8) ? 8 : ((sh_dest_depth > sd) ? sd : sh_dest_depth);
        qlim = (dd < sd - 1) ? dd : sd - 1;
        qd = (sh_quant_depth < 1) ? 1 : ((sh_quant_depth > qlim) ? qlim : sh_quant_depth);
        w = (sh_line_width < 1) ? 1 : ((sh_line_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF
                                                                         : sh_line_width);
        divisor = 1 << (sd - qd);
        rounder = divisor / 2;
        maxo = (1 << dd) - 1;
        smax = (1 << sd) - 1;
        qmax = (1 << qd) - 1;
        low = (qd < 8);

        if (restart)
        begin
            clear_diffusion();
        end
        if (col_done >= w)
        begin
            col_done = 0;
        end

        value = int'(pixel) & smax;
        if (sh_range_convert)
        begin
            t = (longint'(value) - longint'(sh_src_offset)) * longint'(sh_range_gain)
                + longint'(sh_dst_offset) * 65536 + 32768;
            if (t < 0)
            begin
                value = 0;
            end
            else
            begin
                value = ((t >>> 16) > smax) ? smax : int'(t >>> 16);
            end
        end

        err = err_carry;
        if (low)
        begin
            err -= rounder;
        end
        sum = value + err;
        q = floor_div(sum + rounder, divisor);
        err = sum - q * divisor;

        if (low)
        begin
            qc = (q < qmax) ? q : qmax;
            if (qc <= 0)
            begin
                res = 0;
            end
            else
            begin
                res = int'((2 * longint'(qc) * maxo + qmax) / (2 * longint'(qmax)));
            end
        end
        else
        begin
            res = q * (1 << (dd - qd));
        end
        if (res < 0)
        begin
            res = 0;
        end
        if (res > maxo)
        begin
            res = maxo;
        end

        x = odd_row ? (w - 1 - int'(col_done)) : int'(col_done);
        dir = odd_row ? -1 : 1;
        pos = x + 1;

        // Split the residual: 4/16 behind, 5/16 below, the rest ahead.
        e3 = floor_div(err * 4 + 8, 16);
        e5 = floor_div(err * 5 + 8, 16);
        e7 = err - e3 - e5;
        err_carry = err_row[pos + dir] + e7;
        err_row[pos - dir] += e3;
        err_row[pos] += e5;
        err_row[pos + dir] = 0;

        col_done++;
        if (col_done >= w)
        begin
            col_done = 0;
            odd_row = ~odd_row;
        end

        r.value = res[15:0];
        r.column = x[11:0];
        return r;
    endfunction

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Output side: stall per mode, check every accepted beat.
    always @(posedge clk)
    begin
        dithered_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected output beat: out_value %0d column %0d",
                       m_tdata[15:0], m_tdata[27:16]);
                failed <= 1'b1;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (m_tdata[15:0] !== want.value)
                begin
                    $error("out_value: expected %0d, got %0d", want.value, m_tdata[15:0]);
                    failed <= 1'b1;
                end
                if (m_tdata[27:16] !== want.column)
                begin
                    $error("column: expected %0d, got %0d", want.column, m_tdata[27:16]);
                    failed <= 1'b1;
                end
            end
        end
        if (idle_mode == IDLE_RECEIVER || idle_mode == IDLE_BOTH)
        begin
            m_tready <= ($urandom_range(99) >= ((idle_mode == IDLE_BOTH) ? 35 : 81));
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [17:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        shadow_write(idx, data);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every result is back, then let the pipeline settle.
    task automatic drain();
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Offer one beat, hold it until accepted, then predict its result.
    // Valid stays high between back-to-back beats.
    task automatic send_pixel(logic [15:0] pixel, logic restart, int want_value,
                              int want_column);
        dithered_t r;
        if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH)
        begin
            while ($urandom_range(99) < ((idle_mode == IDLE_BOTH) ? 35 : 81))
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= pixel;
        s_tuser <= restart;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        r = dither_pixel(pixel, restart);
        if (want_value >= 0 && want_value != r.value)
        begin
            $error("out_value: expected %0d, got %0d", want_value, r.value);
            failed = 1'b1;
        end
        if (want_column >= 0 && want_column != r.column)
        begin
            $error("column: expected %0d, got %0d", want_column, r.column);
            failed = 1'b1;
        end
        pending_pixels.push_back(r);
    endtask

    task automatic release_valid();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    directed_row_t directed[] = '{
        // reset setup: 8-bit in and out, four quant bits, low mode
        '{16'h0000, 1'b0, 0, 0},
        '{16'h00ff, 1'b1, 255, 0},
        '{16'h0080, 1'b0, -1, 1},
        '{16'hff7f, 1'b0, -1, 2},     // bits above the source depth are dropped
        '{16'h0000, 1'b0, -1, -1},
        '{16'h00ff, 1'b0, -1, -1},
        '{16'hffff, 1'b0, -1, -1},
        '{16'h0001, 1'b0, -1, -1},
        '{16'h00fe, 1'b0, -1, -1},
        '{16'h0040, 1'b0, -1, -1},
        '{16'h0000, 1'b1, 0, 0},
        '{16'h0010, 1'b0, -1, -1},
        '{16'h00f0, 1'b0, -1, -1},
        '{16'h8000, 1'b0, -1, -1}
    };

    // Per-phase register sets: extremes first, then random.
    task automatic load_phase(int p);
        logic [17:0] v [8];
        foreach (v[i])
        begin
            v[i] = $urandom;
        end
        v[CFG_SOURCE_DEPTH] = $urandom_range(31);
        v[CFG_DEST_DEPTH] = $urandom_range(31);
        v[CFG_QUANT_DEPTH] = $urandom_range(15);
        v[CFG_LINE_WIDTH] = $urandom_range(1, 24);
        case (p)
            0:
            begin
                v[CFG_SOURCE_DEPTH] = 16;
                v[CFG_DEST_DEPTH] = 16;
                v[CFG_QUANT_DEPTH] = 15;
                v[CFG_LINE_WIDTH] = 1;
                v[CFG_RANGE_CONVERT] = 0;
            end
            1:
            begin
                v[CFG_SOURCE_DEPTH] = 8;
                v[CFG_DEST_DEPTH] = 8;
                v[CFG_QUANT_DEPTH] = 1;
                v[CFG_LINE_WIDTH] = MAX_WIDTH_DEF;
                v[CFG_RANGE_CONVERT] = 1;
                v[CFG_SRC_OFFSET] = 0;
                v[CFG_RANGE_GAIN] = 18'h3ffff;
                v[CFG_DST_OFFSET] = 18'h10000;   // most negative offset
            end
            2:
            begin
                v[CFG_SOURCE_DEPTH] = 31;
                v[CFG_DEST_DEPTH] = 0;
                v[CFG_QUANT_DEPTH] = 0;
                v[CFG_LINE_WIDTH] = 0;
                v[CFG_RANGE_CONVERT] = 1;
                v[CFG_SRC_OFFSET] = 16'hffff;
                v[CFG_RANGE_GAIN] = 0;
                v[CFG_DST_OFFSET] = 18'h0ffff;
            end
            3:
            begin
                v[CFG_SOURCE_DEPTH] = 12;
                v[CFG_DEST_DEPTH] = 10;
                v[CFG_QUANT_DEPTH] = 8;
                v[CFG_LINE_WIDTH] = 13'h1fff;    // clamps to the maximum
                v[CFG_RANGE_CONVERT] = 0;
            end
            default: ;
        endcase
        for (int i = 0; i < 8; i++)
        begin
            write_reg(cfg_index_t'(i), v[i]);
        end
    endtask

    initial
    begin
        logic [15:0] pixel;
        sh_source_depth = 8;
        sh_dest_depth = 8;
        sh_quant_depth = 4;
        sh_line_width = 4096;
        sh_range_convert = 0;
        sh_src_offset = 0;
        sh_range_gain = 65536;
        sh_dst_offset = 0;
        clear_diffusion();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            send_pixel(directed[i].pixel, directed[i].restart,
                       directed[i].want_value, directed[i].want_column);
        end
        release_valid();
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            load_phase(p);
            idle_mode = idle_mode_t'(p % 4);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                pixel = $urandom;
                // Mostly in-range samples, sometimes full-width noise.
                if ($urandom_range(3) != 0)
                begin
                    pixel = pixel & ((17'h1 << ((sh_source_depth < 8) ? 8 :
                            (sh_source_depth > 16) ? 16 : sh_source_depth)) - 1);
                end
                send_pixel(pixel, ($urandom_range(63) == 0), -1, -1);
            end
            release_valid();
            drain();
        end

        if (!failed)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sedd_pkg.sv
rtl/sedd_front.sv
rtl/sedd_queue.sv
rtl/sedd_back.sv
rtl/serpentine_error_diffusion_dither_unit.sv
dv/serpentine_error_diffusion_dither_unit_tb.sv
